// ===== rtl/core/pnpp_pkg.sv =====
// Package for the polyline nearest-point projector.
// Holds the default sizes, the input kind codes and the sequencer state codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pnpp_pkg;

  // Default sizes (coordinates are Q16.16 at the default width)
  localparam int MaxVertices = 32;
  localparam int CoordWidth  = 32;

  // Input kinds carried on tuser
  localparam logic KindLoad    = 1'b0;
  localparam logic KindProject = 1'b1;

  // Sequencer states, one-hot
  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_RDA    = 12'b0000_0000_0010,
    ST_RDB    = 12'b0000_0000_0100,
    ST_DIFF   = 12'b0000_0000_1000,
    ST_MUL    = 12'b0000_0001_0000,
    ST_DECIDE = 12'b0000_0010_0000,
    ST_PMUL   = 12'b0000_0100_0000,
    ST_DIV    = 12'b0000_1000_0000,
    ST_AXIS   = 12'b0001_0000_0000,
    ST_ERR    = 12'b0010_0000_0000,
    ST_SQ     = 12'b0100_0000_0000,
    ST_FINISH = 12'b1000_0000_0000
  } state_e;

endpackage
`default_nettype wire

// ===== rtl/core/polyline_nearest_point_projector.sv =====
// Polyline nearest-point projector: vertex store, shared multiplier,
// restoring divider and the sequencer around them. Depends on pnpp_pkg.
//
// Channel   Dir  Handshake              Payload
// s_axis    in   s_axis_tvalid/tready   tuser=kind, tdata=index,x,y,z
// m_axis    out  m_axis_tvalid/tready   tuser=no_segment, tdata=x,y,z,segment
// cfg       in   cfg_we_i               cfg_data_i = vertex_count
//
// A load word is written to the vertex store when it is taken, if its index is
// in range. A project word reads both ends of each segment, forms differences
// and dot products, then clamps to an endpoint or divides once per axis on the
// bit-per-cycle divider, and squares the error on the one shared multiplier.
// The input is not ready during a projection. Reset clears control and the
// vertex count; the vertex store is not cleared. A finished result waits in
// the output register while the next word is taken.
`timescale 1ns / 1ps
`default_nettype none
module polyline_nearest_point_projector #(
  parameter int MAX_VERTICES = pnpp_pkg::MaxVertices,
  parameter int COORD_WIDTH  = pnpp_pkg::CoordWidth
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      cfg_we_i,
  input  wire logic [5:0]                                cfg_data_i,
  input  wire logic                                      s_axis_tvalid,
  output logic                                           s_axis_tready,
  // tdata: vertex_index[4:0], x_coord, y_coord, z_coord, zero fill
  input  wire logic [((5+3*COORD_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  // tuser: kind
  input  wire logic                                      s_axis_tuser,
  output logic                                           m_axis_tvalid,
  input  wire logic                                      m_axis_tready,
  // tdata: proj_x, proj_y, proj_z, segment_found[4:0], zero fill
  output logic [((5+3*COORD_WIDTH+7)/8)*8-1:0]           m_axis_tdata,
  // tuser: no_segment
  output logic                                           m_axis_tuser
);

  localparam int C   = COORD_WIDTH;
  localparam int AW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int SW  = (AW + 1 > 6) ? AW + 1 : 6;
  localparam int IW  = (AW > 5) ? AW : 5;
  localparam int BW  = (AW > 5) ? AW : 5;
  localparam int TW  = ((5 + 3 * C + 7) / 8) * 8;
  localparam int DW  = C + 1;
  localparam int MW  = C + 2;
  localparam int PW  = 2 * MW;
  localparam int QW  = 2 * C + 2;
  localparam int NW  = 2 * C + 3;
  localparam int XW  = 3 * C + 3;
  localparam int CNW = $clog2(DW + 1);

  pnpp_pkg::state_e state_q, state_d;

  // Vertex store, x in the low half
  logic [2*C-1:0] mem [MAX_VERTICES];
  logic [2*C-1:0] rdata_q;
  logic [AW-1:0]  rd_addr;

  // Control
  logic [5:0]    vcount_q;
  logic [SW-1:0] count_q;
  logic [AW-1:0] i_q;
  logic [2:0]    step_q;
  logic          axis_q;
  logic [CNW-1:0] cnt_q;
  logic          have_q;
  logic          out_valid_q;

  // Datapath
  logic [C-1:0]  px_q, py_q, pz_q, ax_q, ay_q, bx_q, by_q, qx_q, qy_q;
  logic [DW-1:0] dx_q, dy_q, wx_q, wy_q, ex_q, ey_q;
  logic [QW-1:0] den_q, lo_q, rem_q, best_d_q;
  logic [NW-1:0] num_q;
  logic [DW-1:0] nlow_q, quo_q;
  logic          no_seg_q;
  logic [C-1:0]  best_x_q, best_y_q;
  logic [AW-1:0] best_i_q;
  logic signed [PW-1:0] prod_q;
  logic [TW-1:0] out_data_q;
  logic          out_user_q;

  // Input unpack
  logic [4:0]    in_idx;
  logic [C-1:0]  in_x, in_y, in_z;
  logic [IW-1:0] idx_w;
  logic          in_fire, wr_ok;
  logic [SW-1:0] vcount_w;

  assign in_idx   = s_axis_tdata[4:0];
  assign in_x     = s_axis_tdata[5 +: C];
  assign in_y     = s_axis_tdata[5 + C +: C];
  assign in_z     = s_axis_tdata[5 + 2*C +: C];
  assign idx_w    = IW'(in_idx);
  assign wr_ok    = (IW+1)'(idx_w) < (IW+1)'(MAX_VERTICES);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign vcount_w = SW'(vcount_q);

  assign s_axis_tready = (state_q == pnpp_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // Shared multiplier operand select
  logic signed [MW-1:0] op_a, op_b;
  logic signed [PW-1:0] prod_d;
  logic [DW-1:0] mag;
  logic [DW-1:0] d_sel;

  assign d_sel = axis_q ? dy_q : dx_q;
  assign mag   = d_sel[DW-1] ? DW'(-d_sel) : d_sel;

  always_comb begin
    op_a = '0;
    op_b = '0;
    if (state_q == pnpp_pkg::ST_MUL) begin
      unique case (step_q)
        3'd0: begin op_a = {dx_q[DW-1], dx_q}; op_b = {dx_q[DW-1], dx_q}; end
        3'd1: begin op_a = {dy_q[DW-1], dy_q}; op_b = {dy_q[DW-1], dy_q}; end
        3'd2: begin op_a = {wx_q[DW-1], wx_q}; op_b = {dx_q[DW-1], dx_q}; end
        3'd3: begin op_a = {wy_q[DW-1], wy_q}; op_b = {dy_q[DW-1], dy_q}; end
        default: begin op_a = '0; op_b = '0; end
      endcase
    end else if (state_q == pnpp_pkg::ST_PMUL) begin
      op_a = {1'b0, mag};
      op_b = (step_q == 3'd0) ? {1'b0, num_q[DW-1:0]} : {1'b0, num_q[2*DW-1:DW]};
    end else if (state_q == pnpp_pkg::ST_SQ) begin
      op_a = (step_q == 3'd0) ? {ex_q[DW-1], ex_q} : {ey_q[DW-1], ey_q};
      op_b = op_a;
    end
  end

  assign prod_d = op_a * op_b;

  // Memory read address: start vertex, then end vertex
  assign rd_addr = (state_q == pnpp_pkg::ST_RDB) ? AW'(i_q + 1'b1) : i_q;

  // Decision, division and compare helpers
  logic          clamp_a, clamp_b;
  logic [XW-1:0] n_full;
  logic [QW:0]   trial, trial_sub;
  logic          trial_ge;
  logic [C-1:0]  q_coord, a_sel;
  logic [QW-1:0] d2;
  logic          better, more_seg, out_free;

  assign clamp_a  = (den_q == '0) || num_q[NW-1] || (num_q == '0);
  assign clamp_b  = $signed(num_q) >= $signed({1'b0, den_q});
  assign n_full   = XW'(lo_q) + (XW'(prod_q[QW-1:0]) << DW) + XW'(den_q >> 1);
  assign trial    = {rem_q, nlow_q[DW-1]};
  assign trial_sub = trial - {1'b0, den_q};
  assign trial_ge = trial >= {1'b0, den_q};
  assign a_sel    = axis_q ? ay_q : ax_q;
  assign q_coord  = d_sel[DW-1] ? a_sel - quo_q[C-1:0] : a_sel + quo_q[C-1:0];
  assign d2       = lo_q + prod_q[QW-1:0];
  assign better   = !have_q || (d2 < best_d_q);
  assign more_seg = (SW'(i_q) + SW'(2)) < count_q;
  assign out_free = !out_valid_q || m_axis_tready;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pnpp_pkg::ST_IDLE: begin
        if (in_fire && s_axis_tuser == pnpp_pkg::KindProject) begin
          state_d = ((vcount_w < SW'(MAX_VERTICES) ? vcount_w : SW'(MAX_VERTICES)) < SW'(2))
                    ? pnpp_pkg::ST_FINISH : pnpp_pkg::ST_RDA;
        end
      end
      pnpp_pkg::ST_RDA:  state_d = pnpp_pkg::ST_RDB;
      pnpp_pkg::ST_RDB:  state_d = pnpp_pkg::ST_DIFF;
      pnpp_pkg::ST_DIFF: state_d = pnpp_pkg::ST_MUL;
      pnpp_pkg::ST_MUL:  if (step_q == 3'd4) state_d = pnpp_pkg::ST_DECIDE;
      pnpp_pkg::ST_DECIDE: begin
        state_d = (clamp_a || clamp_b) ? pnpp_pkg::ST_ERR : pnpp_pkg::ST_PMUL;
      end
      pnpp_pkg::ST_PMUL: if (step_q == 3'd2) state_d = pnpp_pkg::ST_DIV;
      pnpp_pkg::ST_DIV:  if (cnt_q == CNW'(DW - 1)) state_d = pnpp_pkg::ST_AXIS;
      pnpp_pkg::ST_AXIS: state_d = axis_q ? pnpp_pkg::ST_ERR : pnpp_pkg::ST_PMUL;
      pnpp_pkg::ST_ERR:  state_d = pnpp_pkg::ST_SQ;
      pnpp_pkg::ST_SQ: begin
        if (step_q == 3'd2) state_d = more_seg ? pnpp_pkg::ST_RDA : pnpp_pkg::ST_FINISH;
      end
      pnpp_pkg::ST_FINISH: if (out_free) state_d = pnpp_pkg::ST_IDLE;
      default: state_d = pnpp_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pnpp_pkg::ST_IDLE;
      vcount_q    <= '0;
      count_q     <= '0;
      i_q         <= '0;
      step_q      <= '0;
      axis_q      <= 1'b0;
      cnt_q       <= '0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) vcount_q <= cfg_data_i;
      // Present a finished word, drop it once taken
      if (state_q == pnpp_pkg::ST_FINISH && out_free) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      unique case (state_q)
        pnpp_pkg::ST_IDLE: begin
          count_q <= (vcount_w < SW'(MAX_VERTICES)) ? vcount_w : SW'(MAX_VERTICES);
          i_q     <= '0;
          have_q  <= 1'b0;
        end
        pnpp_pkg::ST_DIFF: step_q <= '0;
        pnpp_pkg::ST_MUL:  step_q <= (step_q == 3'd4) ? 3'd0 : step_q + 3'd1;
        pnpp_pkg::ST_DECIDE: begin
          axis_q <= 1'b0;
          step_q <= '0;
        end
        pnpp_pkg::ST_PMUL: begin
          step_q <= (step_q == 3'd2) ? 3'd0 : step_q + 3'd1;
          cnt_q  <= '0;
        end
        pnpp_pkg::ST_DIV:  cnt_q <= cnt_q + 1'b1;
        pnpp_pkg::ST_AXIS: axis_q <= 1'b1;
        pnpp_pkg::ST_ERR:  step_q <= '0;
        pnpp_pkg::ST_SQ: begin
          step_q <= (step_q == 3'd2) ? 3'd0 : step_q + 3'd1;
          if (step_q == 3'd2) begin
            if (better) have_q <= 1'b1;
            i_q <= i_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Vertex store write and registered read
  always_ff @(posedge clk_i) begin
    if (in_fire && s_axis_tuser == pnpp_pkg::KindLoad && wr_ok) begin
      mem[idx_w[AW-1:0]] <= {in_y, in_x};
    end
    rdata_q <= mem[rd_addr];
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    unique case (state_q)
      pnpp_pkg::ST_IDLE: begin
        px_q     <= in_x;
        py_q     <= in_y;
        pz_q     <= in_z;
        best_x_q <= '0;
        best_y_q <= '0;
        best_i_q <= '0;
        best_d_q <= '0;
        no_seg_q <= 1'b1;
      end
      pnpp_pkg::ST_RDB: begin
        ax_q <= rdata_q[C-1:0];
        ay_q <= rdata_q[2*C-1:C];
        wx_q <= {px_q[C-1], px_q} - {rdata_q[C-1], rdata_q[C-1:0]};
        wy_q <= {py_q[C-1], py_q} - {rdata_q[2*C-1], rdata_q[2*C-1:C]};
      end
      pnpp_pkg::ST_DIFF: begin
        bx_q <= rdata_q[C-1:0];
        by_q <= rdata_q[2*C-1:C];
        dx_q <= {rdata_q[C-1], rdata_q[C-1:0]} - {ax_q[C-1], ax_q};
        dy_q <= {rdata_q[2*C-1], rdata_q[2*C-1:C]} - {ay_q[C-1], ay_q};
      end
      pnpp_pkg::ST_MUL: begin
        unique case (step_q)
          3'd1: den_q <= prod_q[QW-1:0];
          3'd2: den_q <= den_q + prod_q[QW-1:0];
          3'd3: num_q <= prod_q[NW-1:0];
          3'd4: num_q <= num_q + prod_q[NW-1:0];
          default: ;
        endcase
      end
      pnpp_pkg::ST_DECIDE: begin
        if (clamp_a) begin
          qx_q <= ax_q;
          qy_q <= ay_q;
        end else if (clamp_b) begin
          qx_q <= bx_q;
          qy_q <= by_q;
        end
      end
      pnpp_pkg::ST_PMUL: begin
        if (step_q == 3'd1) lo_q <= prod_q[QW-1:0];
        if (step_q == 3'd2) begin
          rem_q  <= n_full[XW-1:DW];
          nlow_q <= n_full[DW-1:0];
          quo_q  <= '0;
        end
      end
      pnpp_pkg::ST_DIV: begin
        rem_q  <= trial_ge ? trial_sub[QW-1:0] : trial[QW-1:0];
        nlow_q <= {nlow_q[DW-2:0], 1'b0};
        quo_q  <= {quo_q[DW-2:0], trial_ge};
      end
      pnpp_pkg::ST_AXIS: begin
        if (axis_q) qy_q <= q_coord;
        else        qx_q <= q_coord;
      end
      pnpp_pkg::ST_ERR: begin
        ex_q <= {px_q[C-1], px_q} - {qx_q[C-1], qx_q};
        ey_q <= {py_q[C-1], py_q} - {qy_q[C-1], qy_q};
      end
      pnpp_pkg::ST_SQ: begin
        if (step_q == 3'd1) lo_q <= prod_q[QW-1:0];
        if (step_q == 3'd2 && better) begin
          best_d_q <= d2;
          best_x_q <= qx_q;
          best_y_q <= qy_q;
          best_i_q <= i_q;
          no_seg_q <= 1'b0;
        end
      end
      pnpp_pkg::ST_FINISH: begin
        if (out_free) begin
          out_data_q <= TW'({5'(BW'(best_i_q)), pz_q, best_y_q, best_x_q});
          out_user_q <= no_seg_q;
        end
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  // Divider remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pnpp_pkg::ST_DIV) |-> (rem_q < den_q))
    else $error("divider remainder out of range");

  // Rounded offset never passes the segment end
  a_quo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pnpp_pkg::ST_AXIS) |-> (quo_q <= mag))
    else $error("projection offset beyond segment");

  // Leaving FINISH always presents a word
  a_finish_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pnpp_pkg::ST_FINISH && out_free) |=> m_axis_tvalid)
    else $error("result word not presented");
`endif

endmodule
`default_nettype wire
